/* src/tosrm_pkg.sv */
package tosrm_pkg;

	localparam int WINDOW_BYTES = 42;
	localparam int BC_W         = $clog2(WINDOW_BYTES + 1);

	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int DESC_DEPTH = 4;
	localparam int DESC_AW    = $clog2(DESC_DEPTH);

	// byte positions that classification and rewrite can ever look at
	localparam int CAP_LO = 12;
	localparam int CAP_HI = 33;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_VLAN  = 2'd1;
	localparam logic [1:0] KIND_PPPOE = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam logic [1:0] VERDICT_DROP = 2'd1;

	localparam logic [1:0] CFG_TOS_VALUE = 2'd0;
	localparam logic [1:0] CFG_TOS_MASK  = 2'd1;
	localparam logic [1:0] CFG_VERDICT   = 2'd2;

	localparam logic [15:0] ET_IPV4  = 16'h0800;
	localparam logic [15:0] ET_VLAN  = 16'h8100;
	localparam logic [15:0] ET_PPPOE = 16'h8864;
	localparam logic [15:0] PPP_IPV4 = 16'h0021;

	localparam logic [BC_W-1:0] OFF_ETH   = BC_W'(14);
	localparam logic [BC_W-1:0] OFF_VLAN  = BC_W'(18);
	localparam logic [BC_W-1:0] OFF_PPPOE = BC_W'(22);
	localparam logic [BC_W-1:0] IP_HDR_BYTES = BC_W'(20);
	localparam logic [BC_W-1:0] TOS_IDX   = BC_W'(1);
	localparam logic [BC_W-1:0] CK_IDX    = BC_W'(10);

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [1:0] verdict;
		logic [1:0] encap_kind;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [1:0]  kind;
		logic        rewrite;
		logic [7:0]  new_tos;
		logic [15:0] new_ck;
	} desc_t;

	typedef struct packed {
		logic             byte_full;
		logic [DESC_AW:0] desc_cnt;
	} q_stat_t;

	function automatic logic [BC_W-1:0] hdr_off(input logic [1:0] kind);
		logic [BC_W-1:0] off;
		unique case (kind)
			KIND_VLAN:  off = OFF_VLAN;
			KIND_PPPOE: off = OFF_PPPOE;
			default:    off = OFF_ETH;
		endcase
		return off;
	endfunction

endpackage

/* src/ipv4_tos_remark_with_checksum.sv */
// IPv4 TOS remarker: takes an Ethernet frame one byte per transfer, finds the IPv4 header
// (byte 14 plain or fallback, 18 behind an 802.1Q tag, 22 inside a PPPoE session),
// rewrites TOS under tos_mask and patches the header checksum incrementally. Bytes of a
// frame come out only once its first 42 bytes (or the whole frame, if shorter) have
// been taken in and its descriptor has been queued; from then on input and output each
// move one byte per cycle while output is popped and input is not held. The front stalls
// input (full) when the 64-entry byte buffer is full or the 4-entry descriptor queue
// between front and back has no room, so frames shorter than the window can cost extra
// cycles when they follow back to back. Frames whose header does not fit in the window
// are passed unchanged with verdict drop. Configuration is accepted every cycle; write
// it only while no frame is in flight.
module ipv4_tos_remark_with_checksum import tosrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  frame,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	q_stat_t          q_stat;
	logic             byte_wr;
	in_item_t         byte_wr_data;
	logic             byte_full;
	logic             desc_push;
	desc_t            desc_data;
	logic             rd_valid;
	in_item_t         rd_data;
	logic             rd_ready;
	logic             desc_pop;
	logic             desc_valid;
	desc_t            desc_head;
	logic [DESC_AW:0] desc_cnt;

	assign q_stat.byte_full = byte_full;
	assign q_stat.desc_cnt  = desc_cnt;

	tosrm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.frame        (frame),
		.full         (full),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_stat       (q_stat),
		.byte_wr      (byte_wr),
		.byte_wr_data (byte_wr_data),
		.desc_push    (desc_push),
		.desc_data    (desc_data)
	);

	tosrm_byte_fifo u_byte_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (byte_wr),
		.wr_data  (byte_wr_data),
		.wr_full  (byte_full),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.rd_ready (rd_ready)
	);

	tosrm_desc_fifo u_desc_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (desc_push),
		.push_data  (desc_data),
		.pop        (desc_pop),
		.head_valid (desc_valid),
		.head       (desc_head),
		.cnt        (desc_cnt)
	);

	tosrm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (rd_valid),
		.rd_data    (rd_data),
		.rd_ready   (rd_ready),
		.desc_valid (desc_valid),
		.desc       (desc_head),
		.desc_pop   (desc_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* src/tosrm_front.sv */
module tosrm_front import tosrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  in_item_t          frame,
	output logic              full,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  q_stat_t           q_stat,
	output logic              byte_wr,
	output in_item_t          byte_wr_data,
	output logic              desc_push,
	output desc_t             desc_data
);

	logic [7:0]      tos_value_q;
	logic [7:0]      tos_mask_q;
	logic [1:0]      verdict_code_q;
	logic [BC_W-1:0] byte_count_q;
	logic            flushed_q;
	logic            pend_q;
	logic [BC_W-1:0] pend_n_q;
	logic [7:0]      hb_q [CAP_LO:CAP_HI];

	logic            accept;
	logic            close;
	logic [BC_W-1:0] cnt_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tos_value_q    <= '0;
			tos_mask_q     <= '0;
			verdict_code_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOS_VALUE: tos_value_q    <= cfg_data;
				CFG_TOS_MASK:  tos_mask_q     <= cfg_data;
				CFG_VERDICT:   verdict_code_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// hold back a byte while the byte buffer is full or a descriptor slot might be missing
	assign full = q_stat.byte_full ||
		(({1'b0, q_stat.desc_cnt} + {{(DESC_AW+1){1'b0}}, pend_q}) >=
		(DESC_AW+2)'(DESC_DEPTH));
	assign accept = push && !full;
	assign cnt_n  = byte_count_q + BC_W'(1);
	assign close  = accept && !flushed_q &&
		((cnt_n == BC_W'(WINDOW_BYTES)) || frame.frame_last);

	assign byte_wr      = accept;
	assign byte_wr_data = frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			flushed_q    <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			pend_q <= close;
			if (accept) begin
				if (frame.frame_last) begin
					byte_count_q <= '0;
					flushed_q    <= 1'b0;
				end else if (!flushed_q) begin
					byte_count_q <= cnt_n;
					flushed_q    <= close;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close)
			pend_n_q <= cnt_n;
		if (accept && !flushed_q && byte_count_q >= BC_W'(CAP_LO) &&
				byte_count_q <= BC_W'(CAP_HI))
			hb_q[byte_count_q] <= frame.frame_byte;
	end

	// classify the closed window and work out the new TOS and checksum
	logic [15:0]     et;
	logic [1:0]      kind;
	logic [BC_W-1:0] off;
	logic            rewrite;
	logic [7:0]      old_tos;
	logic [7:0]      new_tos;
	logic [15:0]     hc;
	logic [17:0]     sum;
	logic [16:0]     fold1;
	logic [15:0]     fold2;

	always_comb begin
		et   = {hb_q[12], hb_q[13]};
		kind = KIND_OTHER;
		if (pend_n_q >= BC_W'(14)) begin
			priority if (et == ET_IPV4)
				kind = KIND_PLAIN;
			else if (et == ET_VLAN && pend_n_q >= BC_W'(18) &&
					{hb_q[16], hb_q[17]} == ET_IPV4)
				kind = KIND_VLAN;
			else if (et == ET_PPPOE && pend_n_q >= BC_W'(22) &&
					{hb_q[20], hb_q[21]} == PPP_IPV4)
				kind = KIND_PPPOE;
		end
		off     = hdr_off(kind);
		rewrite = ({1'b0, off} + {1'b0, IP_HDR_BYTES}) <= {1'b0, pend_n_q};
		unique case (kind)
			KIND_VLAN: begin
				old_tos = hb_q[19];
				hc      = {hb_q[28], hb_q[29]};
			end
			KIND_PPPOE: begin
				old_tos = hb_q[23];
				hc      = {hb_q[32], hb_q[33]};
			end
			default: begin
				old_tos = hb_q[15];
				hc      = {hb_q[24], hb_q[25]};
			end
		endcase
		new_tos = (old_tos & ~tos_mask_q) | (tos_value_q & tos_mask_q);
		sum     = {2'b00, ~hc} + {2'b00, 8'hff, ~old_tos} + {10'd0, new_tos};
		fold1   = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
		fold2   = fold1[15:0] + {15'd0, fold1[16]};
	end

	assign desc_push         = pend_q;
	assign desc_data.verdict = rewrite ? verdict_code_q : VERDICT_DROP;
	assign desc_data.kind    = kind;
	assign desc_data.rewrite = rewrite;
	assign desc_data.new_tos = new_tos;
	assign desc_data.new_ck  = ~fold2;

endmodule

/* src/tosrm_byte_fifo.sv */
module tosrm_byte_fifo import tosrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  in_item_t wr_data,
	output logic     wr_full,
	output logic     rd_valid,
	output in_item_t rd_data,
	input  logic     rd_ready
);

	in_item_t           mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               dv_q;
	logic               mem_rd;

	assign wr_full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign mem_rd   = (cnt_q != '0) && (!dv_q || rd_ready);
	assign rd_valid = dv_q;

	always_ff @(posedge clk) begin
		if (wr)
			mem[wp_q] <= wr_data;
		if (mem_rd)
			rd_data <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			dv_q  <= 1'b0;
		end else begin
			if (wr)
				wp_q <= wp_q + FIFO_AW'(1);
			if (mem_rd)
				rp_q <= rp_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(mem_rd);
			if (mem_rd)
				dv_q <= 1'b1;
			else if (rd_ready)
				dv_q <= 1'b0;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !wr_full) else $error("byte buffer written while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("byte buffer count out of range");
	a_ready_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ready |-> dv_q) else $error("read taken with no data staged");

endmodule

/* src/tosrm_desc_fifo.sv */
module tosrm_desc_fifo import tosrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  desc_t            push_data,
	input  logic             pop,
	output logic             head_valid,
	output desc_t            head,
	output logic [DESC_AW:0] cnt
);

	desc_t              slot_q [DESC_DEPTH];
	logic [DESC_AW-1:0] wp_q;
	logic [DESC_AW-1:0] rp_q;
	logic [DESC_AW:0]   cnt_q;

	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rp_q];
	assign cnt        = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + DESC_AW'(1);
			if (pop)
				rp_q <= rp_q + DESC_AW'(1);
			cnt_q <= cnt_q + (DESC_AW+1)'(push) - (DESC_AW+1)'(pop);
		end
	end

	a_desc_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < (DESC_AW+1)'(DESC_DEPTH)) || pop)
		else $error("descriptor queue overflow");

endmodule

/* src/tosrm_back.sv */
module tosrm_back import tosrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_valid,
	input  in_item_t  rd_data,
	output logic      rd_ready,
	input  logic      desc_valid,
	input  desc_t     desc,
	output logic      desc_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic [BC_W-1:0] pos_q;
	logic            ov_q;
	logic            adv;
	logic [BC_W-1:0] off;
	logic [7:0]      byte_n;

	// a byte moves on only once its frame's descriptor is at the head
	assign adv      = rd_valid && desc_valid && (!ov_q || pop);
	assign rd_ready = adv;
	assign desc_pop = adv && rd_data.frame_last;
	assign empty    = !ov_q;
	assign off      = hdr_off(desc.kind);

	always_comb begin
		byte_n = rd_data.frame_byte;
		if (desc.rewrite) begin
			if (pos_q == off + TOS_IDX)
				byte_n = desc.new_tos;
			else if (pos_q == off + CK_IDX)
				byte_n = desc.new_ck[15:8];
			else if (pos_q == off + CK_IDX + BC_W'(1))
				byte_n = desc.new_ck[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= 1'b1;
				if (rd_data.frame_last)
					pos_q <= '0;
				else if (pos_q != '1)
					pos_q <= pos_q + BC_W'(1);
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.out_byte   <= byte_n;
			result.out_last   <= rd_data.frame_last;
			result.verdict    <= desc.verdict;
			result.encap_kind <= desc.kind;
		end
	end

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |-> desc_valid) else $error("descriptor released while none held");
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |=> pos_q == '0) else $error("byte position not restarted at frame end");

endmodule
